@@ sv/pla_pkg.sv @@
// pla_pkg: request/response payload types and code constants for the
// priority lock arbiter. No dependencies.
`default_nettype none

package pla_pkg;

    // Commands carried in a request
    localparam logic [1:0] CMD_LOCK    = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_TRY     = 2'd2;

    // Response status codes
    localparam logic [2:0] ST_ACQUIRED   = 3'd0;
    localparam logic [2:0] ST_QUEUED     = 3'd1;
    localparam logic [2:0] ST_BUSY       = 3'd2;
    localparam logic [2:0] ST_BAD_PRIO   = 3'd3;
    localparam logic [2:0] ST_REL_IDLE   = 3'd4;
    localparam logic [2:0] ST_REL_HANDED = 3'd5;
    localparam logic [2:0] ST_FULL       = 3'd6;

    localparam int unsigned CFG_W   = 5;
    localparam int unsigned PRIO_W  = 4;
    // wide enough for any level number, priority or level count
    localparam int unsigned CMP_W   = 7;
    localparam logic [CFG_W-1:0] LEVELS_RESET = 5'd16;

    typedef struct packed {
        logic [1:0]        command;
        logic [PRIO_W-1:0] priority_req;
    } t_req;

    typedef struct packed {
        logic [2:0]        status;
        logic              handed_valid;
        logic [PRIO_W-1:0] handed_priority;
    } t_rsp;

endpackage

`default_nettype wire

@@ sv/pla_prio_enc.sv @@
// pla_prio_enc: highest-set-bit priority encoder over the waiting flags.
// Standalone; no package needed.
`default_nettype none

module pla_prio_enc #(
    parameter int unsigned N     = 16,
    parameter int unsigned IDX_W = 4
) (
    input  wire logic [N-1:0]     i_req,
    output logic                  o_found,
    output logic [IDX_W-1:0]      o_idx
);

    always_comb begin
        o_idx = '0;
        for (int i = 0; i < N; i++) begin
            if (i_req[i]) begin
                o_idx = IDX_W'(i);
            end
        end
    end

    assign o_found = |i_req;

endmodule

`default_nettype wire

@@ sv/pla_level_bank.sv @@
// pla_level_bank: one waiter counter lane per priority level, with
// increment/decrement strobes and nonzero/full flags. No package needed.
`default_nettype none

module pla_level_bank #(
    parameter int unsigned N      = 16,
    parameter int unsigned CNT_W  = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [N-1:0]  i_inc,
    input  wire logic [N-1:0]  i_dec,
    output logic [N-1:0]       o_nonzero,
    output logic [N-1:0]       o_full
);

    for (genvar g = 0; g < N; g++) begin : g_lane
        logic [CNT_W-1:0] r_count;
        logic [CNT_W-1:0] n_count;

        always_comb begin
            n_count = r_count;
            if (i_inc[g]) begin
                n_count = r_count + CNT_W'(1);
            end else if (i_dec[g]) begin
                n_count = r_count - CNT_W'(1);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_count <= '0;
            end else begin
                r_count <= n_count;
            end
        end

        assign o_nonzero[g] = (r_count != '0);
        assign o_full[g]    = (r_count == '1);
    end

endmodule

`default_nettype wire

@@ sv/priority_lock_arbiter_unit.sv @@
// priority_lock_arbiter_unit: top level of the priority lock arbiter.
// Uses pla_pkg, pla_level_bank and pla_prio_enc.
// An accepted request passes the input register, then the decision and
// response register, before the o_valid strobe. One request per cycle is
// accepted; busy is low whenever reset is released. The receiver cannot
// stall. Synchronous active-low reset frees the lock, clears all waiter
// counts and sets levels_in_use to 16; busy is high during reset.
`default_nettype none

module priority_lock_arbiter_unit
    import pla_pkg::*;
#(
    parameter int unsigned MAX_LEVELS = 16,
    parameter int unsigned COUNT_BITS = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire t_req             i_req,
    output logic                  o_valid,
    output t_rsp                  o_rsp,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int unsigned LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

    // ------------------------------------------------------------------
    // Configuration: levels_in_use
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_levels;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= LEVELS_RESET;
        end else if (i_cfg_we) begin
            r_levels <= i_cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Input register: the request is captured, then decided next cycle
    // ------------------------------------------------------------------
    logic r_req_vld;
    t_req r_req;

    assign busy = ~i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else begin
            r_req_vld <= start & ~busy;
        end
        r_req <= i_req;
    end

    // ------------------------------------------------------------------
    // Level masks. The effective level count is min(levels_in_use,
    // MAX_LEVELS); levels at or above it are invisible, stranded waiters
    // included.
    // ------------------------------------------------------------------
    logic [CMP_W-1:0]      cfg_n;
    logic [CMP_W-1:0]      max_n;
    logic [CMP_W-1:0]      eff_n;
    logic [CMP_W-1:0]      prio_x;
    logic                  bad_prio;
    logic [MAX_LEVELS-1:0] in_use;
    logic [MAX_LEVELS-1:0] above;
    logic [MAX_LEVELS-1:0] sel;

    assign cfg_n    = CMP_W'(r_levels);
    assign max_n    = CMP_W'(MAX_LEVELS);
    assign eff_n    = (cfg_n < max_n) ? cfg_n : max_n;
    assign prio_x   = CMP_W'(r_req.priority_req);
    assign bad_prio = (prio_x >= eff_n);

    always_comb begin
        for (int i = 0; i < MAX_LEVELS; i++) begin
            in_use[i] = (CMP_W'(i) <  eff_n);
            above[i]  = (CMP_W'(i) >  prio_x);
            sel[i]    = (CMP_W'(i) == prio_x);
        end
    end

    // ------------------------------------------------------------------
    // Waiter counters and handover encoder
    // ------------------------------------------------------------------
    logic [MAX_LEVELS-1:0] inc;
    logic [MAX_LEVELS-1:0] dec;
    logic [MAX_LEVELS-1:0] nonzero;
    logic [MAX_LEVELS-1:0] full;
    logic [MAX_LEVELS-1:0] waiting;
    logic                  hand_found;
    logic [LVL_W-1:0]      hand_idx;
    logic [MAX_LEVELS-1:0] hand_oh;
    logic [CMP_W-1:0]      hand_x;
    logic                  higher_waiting;
    logic                  sel_full;

    pla_level_bank #(
        .N     (MAX_LEVELS),
        .CNT_W (COUNT_BITS)
    ) u_bank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_inc     (inc),
        .i_dec     (dec),
        .o_nonzero (nonzero),
        .o_full    (full)
    );

    assign waiting = nonzero & in_use;

    pla_prio_enc #(
        .N     (MAX_LEVELS),
        .IDX_W (LVL_W)
    ) u_enc (
        .i_req   (waiting),
        .o_found (hand_found),
        .o_idx   (hand_idx)
    );

    always_comb begin
        for (int i = 0; i < MAX_LEVELS; i++) begin
            hand_oh[i] = hand_found && (hand_idx == LVL_W'(i));
        end
    end

    assign hand_x         = CMP_W'(hand_idx);
    assign higher_waiting = |(waiting & above);
    assign sel_full       = |(full & sel);

    // ------------------------------------------------------------------
    // Decision
    // ------------------------------------------------------------------
    logic r_lock;
    logic n_lock;
    t_rsp n_rsp;

    always_comb begin
        n_lock = r_lock;
        inc    = '0;
        dec    = '0;
        n_rsp  = '{status: ST_BUSY, handed_valid: 1'b0, handed_priority: '0};
        if (r_req_vld) begin
            unique case (r_req.command) inside
                CMD_LOCK, CMD_TRY: begin
                    if (bad_prio) begin
                        n_rsp.status = ST_BAD_PRIO;
                    end else if (!r_lock && !higher_waiting) begin
                        n_lock       = 1'b1;
                        n_rsp.status = ST_ACQUIRED;
                    end else if (r_req.command == CMD_TRY) begin
                        n_rsp.status = ST_BUSY;
                    end else if (sel_full) begin
                        n_rsp.status = ST_FULL;
                    end else begin
                        inc          = sel;
                        n_rsp.status = ST_QUEUED;
                    end
                end
                CMD_RELEASE: begin
                    if (hand_found) begin
                        // straight handover to the highest waiting level
                        dec                   = hand_oh;
                        n_lock                = 1'b1;
                        n_rsp.status          = ST_REL_HANDED;
                        n_rsp.handed_valid    = 1'b1;
                        n_rsp.handed_priority = hand_x[PRIO_W-1:0];
                    end else begin
                        n_lock       = 1'b0;
                        n_rsp.status = ST_REL_IDLE;
                    end
                end
                default: begin
                    n_rsp.status = ST_BUSY;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Lock flag and response register
    // ------------------------------------------------------------------
    logic r_rsp_vld;
    t_rsp r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock    <= 1'b0;
            r_rsp_vld <= 1'b0;
        end else begin
            r_lock    <= n_lock;
            r_rsp_vld <= r_req_vld;
        end
        r_rsp <= n_rsp;
    end

    assign o_valid = r_rsp_vld;
    assign o_rsp   = r_rsp;

endmodule

`default_nettype wire

@@ sv/pla_checker.sv @@
// pla_checker: port-level assertions for priority_lock_arbiter_unit,
// attached by bind. Uses pla_pkg.
`default_nettype none

module pla_checker
    import pla_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid,
    input wire t_rsp o_rsp
);

    // every accepted request yields a response
    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("request without response");

    // no response without an earlier accepted request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2))
        else $error("spurious response");

    // handover flag and status agree
    a_handed_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.handed_valid == (o_rsp.status == ST_REL_HANDED)))
        else $error("handover flag and status disagree");

    // no handover, no level
    a_handed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rsp.handed_valid) |-> (o_rsp.handed_priority == '0))
        else $error("handed priority set without handover");

endmodule

bind priority_lock_arbiter_unit pla_checker u_pla_checker (.*);

`default_nettype wire
